@@ design/crr_pkg.sv @@
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types, constants and helpers of the column ray-cast renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package crr_pkg;

  localparam int SCREEN_COLUMNS = 120;
  localparam int SCREEN_ROWS    = 42;
  localparam int MAP_SIZE       = 32;
  localparam int MAP_AW         = $clog2(MAP_SIZE);
  localparam int ROW_W          = 32;

  // view spread: 10952 binary-angle units (about 1.05 rad)
  localparam int FOV_UNITS = 10952;
  localparam int HALF_FOV  = FOV_UNITS / 2;
  // column*FOV / SCREEN_COLUMNS as a shift then a reciprocal multiply
  localparam int COL_SHIFT = 3;
  localparam int COL_ODD   = SCREEN_COLUMNS >> COL_SHIFT;
  localparam int COL_RS    = 23;
  localparam int COL_RECIP = (2**COL_RS + COL_ODD - 1) / COL_ODD;

  localparam int QUARTER        = 16384;
  localparam int STEPS_PER_UNIT = 40;
  localparam int MAX_STEPS      = 960;
  localparam int MIN_DIST       = 655;
  localparam int CELL_SPAN      = STEPS_PER_UNIT * 65536;
  localparam int MAP_LIMIT      = MAP_SIZE * CELL_SPAN;
  localparam int HORIZON_Q16    = SCREEN_ROWS * 32768;
  localparam int FLOOR_BASE     = SCREEN_ROWS / 2;

  // divide by five: exact for small values / wide values
  localparam int REC5_S   = 205;
  localparam int REC5_S_RS = 10;
  localparam int DIV5_RS  = 26;
  localparam int DIV5_RECIP = (2**DIV5_RS + 4) / 5;

  localparam int POLY_A = 102944;
  localparam int POLY_B = 42047;
  localparam int POLY_C = 4640;

  localparam int SIN_W     = 18;
  localparam int ACC_W     = 30;
  localparam int K_W       = 11;
  localparam int DIV_NUM_W = 38;
  localparam int DIV_DEN_W = 21;
  localparam logic [DIV_NUM_W-1:0] DIV_NUM = DIV_NUM_W'(SCREEN_ROWS) << 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  localparam logic [7:0] CHAR_SKY   = 8'h20;
  localparam logic [7:0] CHAR_FAR   = 8'h2E;
  localparam logic [7:0] CHAR_NEAR  = 8'h2D;

  typedef struct packed {
    logic        kind;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [20:0] pos_x;
    logic [20:0] pos_y;
    logic [15:0] view_angle;
    logic [6:0]  column;
  } item_t;

  typedef struct packed {
    logic [6:0] out_column;
    logic [5:0] out_row;
    logic [7:0] pixel_char;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                    done;
    logic signed [SIN_W-1:0] value;
  } sin_res_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_res_t;

  function automatic logic [7:0] shade_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h40; // @
      4'd1:    c = 8'h23; // #
      4'd2:    c = 8'h38; // 8
      4'd3:    c = 8'h26; // &
      4'd4:    c = 8'h25; // %
      4'd5:    c = 8'h2A; // *
      4'd6:    c = 8'h2B; // +
      4'd7:    c = 8'h3D; // =
      4'd8:    c = 8'h2D; // -
      4'd9:    c = 8'h3A; // :
      4'd10:   c = 8'h2E; // .
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/column_raycast_renderer.sv @@
// ----------------------------------------------------------------------------
// column_raycast_renderer
// Loads a 32x32 wall map and renders one ASCII screen column per cast.
// ----------------------------------------------------------------------------
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+--------------------------------
//  command  | start, item, busy         | taken when start && !busy
//  result   | result, strobe            | one row per cycle, no back-pressure
//
// Sequence: a load transaction writes the map RAM at its accept edge and
// leaves busy low. A cast holds busy through the column offset, three
// sines (each in the shared polynomial unit), the march (one map RAM read
// per step, up to k, the step that hit: 1 to 959, or 960 with no wall in
// reach), distance, the divider, row bounds and the 42 result rows. The
// bottom row's strobe comes in the first cycle with busy low.
// Reset: the control state clears; map contents stay undefined until
// loaded. The receiver cannot stall: each row is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module column_raycast_renderer import crr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output result_t    result,
  output logic       strobe
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OFF1, ST_OFF2, ST_SINE, ST_MARCH,
    ST_DIST1, ST_DIST2, ST_DIV, ST_ROWS, ST_EMIT
  } state_t;

  typedef struct packed {
    logic              oob;
    logic [MAP_AW-1:0] idx;
  } cell_t;

  // map cell of a Q16*40 coordinate; outside the map counts as wall
  function automatic cell_t cell_of(input logic signed [ACC_W-1:0] n);
    cell_t       c;
    logic [7:0]  m;
    logic [15:0] p;
    m     = n[26:19];
    p     = 16'(m) * 16'(REC5_S);
    c.oob = (n < 0) || (n >= ACC_W'(MAP_LIMIT));
    c.idx = p[REC5_S_RS +: MAP_AW];
    return c;
  endfunction

  state_t                  state;
  logic [6:0]              col;
  logic [20:0]             px;
  logic [20:0]             py;
  logic [15:0]             view;
  logic [20:0]             col_prod;
  logic [15:0]             offu;
  logic [15:0]             ray;
  logic [1:0]              sin_sel;
  logic                    sin_go;
  logic signed [SIN_W-1:0] cs;
  logic signed [SIN_W-1:0] sn;
  logic signed [SIN_W-1:0] coff;
  logic signed [ACC_W-1:0] nx;
  logic signed [ACC_W-1:0] ny;
  logic [K_W-1:0]          issue_k;
  logic                    pend_valid;
  logic [K_W-1:0]          pend_k;
  logic                    pend_oob;
  logic [MAP_AW-1:0]       pend_cx;
  logic [K_W-1:0]          k_fin;
  logic [27:0]             dprod;
  logic [DIV_DEN_W-1:0]    dq;
  logic                    div_go;
  logic signed [15:0]      ce;
  logic signed [15:0]      fl;
  logic [3:0]              shade;
  logic [6:0]              fl_lim;
  logic [5:0]              y;

  // combinational helpers and submodule outputs
  logic [15:0]             sin_angle;
  sin_res_t                sin_res;
  div_res_t                div_res;
  logic [DIV_DEN_W-1:0]    dm;
  logic                    map_we;
  logic [ROW_W-1:0]        map_rdata;
  cell_t                   cx;
  cell_t                   cy;
  logic                    wall;
  logic [37:0]             off_prod;
  logic [13:0]             off_idx;
  logic [15:0]             offu_c;
  logic [16:0]             coff_pos;
  logic [48:0]             dq_prod;
  logic signed [39:0]      v;
  logic [39:0]             v_abs;
  logic signed [15:0]      ce_c;
  logic [24:0]             sh_prod;
  logic [15:0]             sh_div;
  logic [23:0]             fm_prod;
  logic [15:0]             fm_div;
  logic signed [15:0]      ys;
  logic [7:0]              ch;

  assign busy   = (state != ST_IDLE);
  assign map_we = start && !busy && (item.kind == KIND_LOAD);

  always_comb begin
    case (sin_sel)
      2'd0:    sin_angle = ray + 16'(QUARTER);
      2'd1:    sin_angle = ray;
      default: sin_angle = offu + 16'(QUARTER);
    endcase

    // column offset: floor(col*FOV/COLUMNS) - FOV/2, wrapped to 16 bits
    off_prod = 38'(col_prod >> COL_SHIFT) * 38'(COL_RECIP);
    off_idx  = off_prod[COL_RS +: 14];
    offu_c   = 16'(off_idx) - 16'(HALF_FOV);

    cx   = cell_of(nx);
    cy   = cell_of(ny);
    wall = pend_oob || map_rdata[pend_cx];

    coff_pos = coff[SIN_W-1] ? 17'd0 : coff[16:0];
    dq_prod  = 49'(dprod >> 3) * 49'(DIV5_RECIP);
    dm       = (dq < DIV_DEN_W'(MIN_DIST)) ? DIV_DEN_W'(MIN_DIST) : dq;

    // ceiling row, truncated toward zero
    v     = 40'(HORIZON_Q16) - $signed({2'b00, div_res.quotient});
    v_abs = v[39] ? 40'(-v) : 40'(v);
    ce_c  = v[39] ? -$signed(16'(v_abs[39:16])) : $signed(16'(v_abs[39:16]));

    sh_prod = 25'(dq) * 25'd11;
    sh_div  = 16'(sh_prod[24:17]) * 16'(REC5_S);
    fm_prod = 24'(dq) * 24'd9;
    fm_div  = 16'(fm_prod[23:16]) * 16'(REC5_S);

    ys = $signed({10'd0, y});
    if (ys < ce) begin
      ch = CHAR_SKY;
    end else if (ys <= fl) begin
      ch = shade_char(shade);
    end else begin
      ch = ({1'b0, y} > fl_lim) ? CHAR_FAR : CHAR_NEAR;
    end
  end

  crr_ram #(.WIDTH(ROW_W), .DEPTH(MAP_SIZE)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (item.row_index[MAP_AW-1:0]),
    .wdata (item.row_bits),
    .raddr (cy.idx),
    .rdata (map_rdata)
  );

  crr_sin u_sin (
    .clk   (clk),
    .rst   (rst),
    .go    (sin_go),
    .angle (sin_angle),
    .res   (sin_res)
  );

  crr_div u_div (
    .clk    (clk),
    .rst    (rst),
    .go     (div_go),
    .den_in (dm),
    .res    (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      strobe     <= 1'b0;
      sin_go     <= 1'b0;
      div_go     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
      sin_go <= 1'b0;
      div_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start && item.kind == KIND_CAST) begin
            col   <= item.column;
            px    <= item.pos_x;
            py    <= item.pos_y;
            view  <= item.view_angle;
            state <= ST_OFF1;
          end
        end
        ST_OFF1: begin
          col_prod <= 21'(col) * 21'(FOV_UNITS);
          state    <= ST_OFF2;
        end
        ST_OFF2: begin
          offu    <= offu_c;
          ray     <= view + offu_c;
          sin_sel <= 2'd0;
          sin_go  <= 1'b1;
          state   <= ST_SINE;
        end
        ST_SINE: begin
          // cosine of ray, sine of ray, cosine of the offset, in turn
          if (sin_res.done) begin
            case (sin_sel)
              2'd0: begin
                cs      <= sin_res.value;
                sin_sel <= 2'd1;
                sin_go  <= 1'b1;
              end
              2'd1: begin
                sn      <= sin_res.value;
                sin_sel <= 2'd2;
                sin_go  <= 1'b1;
              end
              default: begin
                coff       <= sin_res.value;
                nx         <= ACC_W'(px) * ACC_W'(STEPS_PER_UNIT) + ACC_W'(cs);
                ny         <= ACC_W'(py) * ACC_W'(STEPS_PER_UNIT) + ACC_W'(sn);
                issue_k    <= K_W'(1);
                pend_valid <= 1'b0;
                state      <= ST_MARCH;
              end
            endcase
          end
        end
        ST_MARCH: begin
          // issue step issue_k while the previous step's row comes back
          pend_valid <= 1'b1;
          pend_k     <= issue_k;
          pend_oob   <= cx.oob || cy.oob;
          pend_cx    <= cx.idx;
          nx         <= nx + ACC_W'(cs);
          ny         <= ny + ACC_W'(sn);
          issue_k    <= issue_k + 1'b1;
          if (pend_valid) begin
            if (wall) begin
              k_fin      <= pend_k;
              pend_valid <= 1'b0;
              state      <= ST_DIST1;
            end else if (pend_k == K_W'(MAX_STEPS - 1)) begin
              k_fin      <= K_W'(MAX_STEPS);
              pend_valid <= 1'b0;
              state      <= ST_DIST1;
            end
          end
        end
        ST_DIST1: begin
          dprod <= 28'(k_fin) * 28'(coff_pos);
          state <= ST_DIST2;
        end
        ST_DIST2: begin
          dq     <= dq_prod[DIV5_RS +: DIV_DEN_W];
          div_go <= 1'b1;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            state <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          ce     <= ce_c;
          fl     <= 16'(SCREEN_ROWS) - ce_c;
          shade  <= (sh_div[15:REC5_S_RS] > 6'd11) ? 4'd11 : sh_div[13:REC5_S_RS];
          fl_lim <= 7'(FLOOR_BASE) + 7'(fm_div[15:REC5_S_RS]);
          y      <= '0;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          result.out_column <= col;
          result.out_row    <= y;
          result.pixel_char <= ch;
          result.last       <= (y == 6'(SCREEN_ROWS - 1));
          strobe            <= 1'b1;
          y                 <= y + 1'b1;
          if (y == 6'(SCREEN_ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // rows come only out of the emit phase
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == ST_EMIT)
    else $error("result strobe outside emit phase");

  // the bottom row closes the column
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("row after the last row of a column");

  // rows of one column follow each other without gaps
  a_rows_in_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.out_row == $past(result.out_row) + 1'b1)
    else $error("column rows out of order");

  // map is written only while no cast is running
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    map_we |-> state == ST_IDLE)
    else $error("map write during a cast");

endmodule

`default_nettype wire

@@ design/crr_ram.sv @@
// ----------------------------------------------------------------------------
// crr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/crr_sin.sv @@
// ----------------------------------------------------------------------------
// crr_sin
// Q16 sine from a quarter-wave odd polynomial, one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_sin import crr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [15:0] angle,
  output sin_res_t         res
);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_C1, S_C2, S_C3} state_t;

  state_t      state;
  logic [16:0] x;
  logic [16:0] x2;
  logic [16:0] t;
  logic        neg;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] prod;
  logic [14:0] r_in;
  logic [17:0] s_abs;

  always_comb begin
    case (state)
      S_SQ:    begin mul_a = x;  mul_b = x; end
      S_C1:    begin mul_a = x2; mul_b = 17'(POLY_C); end
      S_C2:    begin mul_a = x2; mul_b = t; end
      S_C3:    begin mul_a = x;  mul_b = t; end
      default: begin mul_a = x;  mul_b = x; end
    endcase
    prod = 34'(mul_a) * 34'(mul_b);
    // odd quadrants run the quarter wave backward
    r_in = angle[14] ? 15'(15'(QUARTER) - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    s_abs = (prod[33:16] > 18'd65536) ? 18'd65536 : prod[33:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            x     <= {r_in, 2'b00};
            neg   <= angle[15];
            state <= S_SQ;
          end
        end
        S_SQ: begin
          x2    <= prod[32:16];
          state <= S_C1;
        end
        S_C1: begin
          t     <= 17'(17'(POLY_B) - prod[32:16]);
          state <= S_C2;
        end
        S_C2: begin
          t     <= 17'(17'(POLY_A) - prod[32:16]);
          state <= S_C3;
        end
        S_C3: begin
          res.value <= neg ? -$signed(s_abs) : $signed(s_abs);
          res.done  <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/crr_div.sv @@
// ----------------------------------------------------------------------------
// crr_div
// Restoring divider, one quotient bit per cycle: SCREEN_ROWS*2^32 / den.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_div import crr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [DIV_DEN_W-1:0] den_in,
  output div_res_t                  res
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial = {rem, res.quotient[DIV_NUM_W-1]};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (go) begin
        running      <= 1'b1;
        cnt          <= CNT_W'(DIV_NUM_W);
        den          <= den_in;
        rem          <= '0;
        res.quotient <= DIV_NUM;
      end else if (running) begin
        rem          <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
        res.quotient <= {res.quotient[DIV_NUM_W-2:0], fits};
        cnt          <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running  <= 1'b0;
          res.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for column_raycast_renderer: loads wall maps, casts
// columns and compares every emitted row against a bit-true column model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import crr_pkg::*;

// Column model: keeps its own copy of the wall map, renders each accepted
// cast into the 42 rows it must produce and checks the rows as they arrive.
class column_shade_model;
  logic [31:0] walls [32];
  result_t     expected_rows [$];
  int          mismatches;

  function new();
    mismatches = 0;
    foreach (walls[i]) walls[i] = '0;
  endfunction

  // quarter-wave odd polynomial, Q16, clamped to one
  function longint sine_q16(longint unsigned ang);
    longint unsigned quad, r, x, x2, t, s;
    ang  = ang & 64'hFFFF;
    quad = ang >> 14;
    r    = ang & 64'h3FFF;
    if (quad[0]) r = 16384 - r;
    x  = r << 2;
    x2 = (x * x) >> 16;
    t  = (x2 * POLY_C) >> 16;
    t  = POLY_B - t;
    t  = (x2 * t) >> 16;
    t  = POLY_A - t;
    s  = (x * t) >> 16;
    if (s > 65536) s = 65536;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  // out-of-map coordinates count as wall
  function bit blocked(longint nx, longint ny);
    longint cx, cy;
    if (nx < 0 || ny < 0) return 1;
    cx = nx / (STEPS_PER_UNIT * 65536);
    cy = ny / (STEPS_PER_UNIT * 65536);
    if (cx >= MAP_SIZE || cy >= MAP_SIZE) return 1;
    return walls[cy][cx];
  endfunction

  function void accept_item(item_t it);
    longint off, offu, ray, cs, sn, coff, k, dq, dm, q, v, ce, fl, fl_lim, shade;
    result_t r;
    if (it.kind == KIND_LOAD) begin
      walls[it.row_index] = it.row_bits;
      return;
    end
    off  = (longint'(it.column) * FOV_UNITS) / SCREEN_COLUMNS - HALF_FOV;
    offu = (65536 + off) & 64'hFFFF;
    ray  = (longint'(it.view_angle) + offu) & 64'hFFFF;
    cs   = sine_q16(ray + QUARTER);
    sn   = sine_q16(ray);
    coff = sine_q16(offu + QUARTER);
    // march until a wall or the reach limit
    for (k = 1; k < MAX_STEPS; k++)
      if (blocked(longint'(it.pos_x) * STEPS_PER_UNIT + cs * k,
                  longint'(it.pos_y) * STEPS_PER_UNIT + sn * k)) break;
    dq = (k * coff) / STEPS_PER_UNIT;           // fisheye corrected
    if (dq < 0) dq = 0;
    dm = (dq < MIN_DIST) ? MIN_DIST : dq;
    q  = (longint'(SCREEN_ROWS) << 32) / dm;
    v  = (longint'(SCREEN_ROWS) << 15) - q;
    ce = v / 65536;                             // truncates toward zero
    fl = SCREEN_ROWS - ce;
    shade = (dq * 11) / (10 * 65536);
    if (shade > 11) shade = 11;
    fl_lim = FLOOR_BASE + (dq * 9) / (5 * 65536);
    for (longint y = 0; y < SCREEN_ROWS; y++) begin
      r.out_column = it.column;
      r.out_row    = y[5:0];
      if (y < ce)            r.pixel_char = CHAR_SKY;
      else if (y <= fl)      r.pixel_char = shade_char(shade[3:0]);
      else if (y > fl_lim)   r.pixel_char = CHAR_FAR;
      else                   r.pixel_char = CHAR_NEAR;
      r.last = (y == SCREEN_ROWS - 1);
      expected_rows = {expected_rows, r};
    end
  endfunction

  function void check_row(result_t got);
    result_t want;
    if (expected_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("tb: unexpected row %p", got);
      return;
    end
    want = expected_rows.pop_front();
    if (got.out_column !== want.out_column || got.out_row !== want.out_row ||
        got.pixel_char !== want.pixel_char || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) $display("tb: row mismatch expected %p actual %p", want, got);
    end
  endfunction
endclass

module tb;
  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  result_t result;
  logic    strobe;

  column_shade_model model;

  column_raycast_renderer i_dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .result(result), .strobe(strobe)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the time that any cast takes.
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

  // Monitor: sees pre-edge values, so acceptance and strobes are race free.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) model.accept_item(item);
      if (strobe) model.check_row(result);
    end
  end

  // One transaction: random idle gap, then hold start until taken.
  task automatic send(item_t it);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;   // keep some back-to-back runs
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_row(int idx, logic [31:0] bits);
    item_t it;
    it = '0;
    // noise in unused fields
    it.pos_x      = 21'($urandom());
    it.pos_y      = 21'($urandom());
    it.view_angle = 16'($urandom());
    it.column     = 7'($urandom());
    it.kind      = KIND_LOAD;
    it.row_index = idx[4:0];
    it.row_bits  = bits;
    send(it);
  endtask

  task automatic cast(logic [20:0] px, logic [20:0] py, logic [15:0] ang, logic [6:0] col);
    item_t it;
    it = '0;
    it.kind       = KIND_CAST;
    it.row_index  = 5'($urandom());
    it.row_bits   = $urandom();
    it.pos_x      = px;
    it.pos_y      = py;
    it.view_angle = ang;
    it.column     = col;
    send(it);
  endtask

  initial begin
    logic [31:0] bits;
    int          wait_cycles;
    model = new();
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: every row written before any cast; empty map first so a ray
    // can run out of reach (distance 24) down a long open corridor.
    for (int r = 0; r < MAP_SIZE; r++) load_row(r, '0);
    cast(21'd65536, 21'd1048576, 16'd5476, 7'd60);       // heading about 30 degrees off +x, no wall
    cast(21'd0, 21'd0, 16'd0, 7'd0);                     // corner, leftmost
    cast(21'h1FFFFF, 21'h1FFFFF, 16'hFFFF, 7'd119);      // far edge, rightmost
    cast(21'h1FFFFF, 21'd0, 16'd16384, 7'd127);          // column past screen
    cast(21'd1048576, 21'd1048576, 16'd16384, 7'd60);    // full-quadrant sine
    cast(21'd1048576, 21'd1048576, 16'd32768, 7'd60);
    load_row(16, 32'hFFFF_FFFF);
    load_row(17, 32'hAAAA_5555);
    cast(21'd1048576, 21'd1050000, 16'd16384, 7'd60);    // wall right beside
    cast(21'd1048576, 21'd1000000, 16'd16384, 7'd30);
    cast(21'd400000, 21'd300000, 16'd49152, 7'd90);

    // Random: sparse maps for long marches, some dense ones for near walls.
    for (int n = 0; n < 160; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       bits = $urandom();
          1:       bits = $urandom() & $urandom();
          default: bits = $urandom() & $urandom() & $urandom() & $urandom();
        endcase
        load_row($urandom_range(0, 31), bits);
      end else begin
        cast(21'($urandom()), 21'($urandom()), 16'($urandom()),
             ($urandom_range(0, 15) == 0) ? 7'($urandom_range(120, 127))
                                          : 7'($urandom_range(0, 119)));
      end
    end
    start <= 1'b0;

    // drain outstanding rows, then a short tail
    wait_cycles = 0;
    while (model.expected_rows.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (model.mismatches == 0 && model.expected_rows.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
